[src/uepr_pkg.sv]
package uepr_pkg;

  // Capture framing.
  localparam int SAMPLES_PER_BLOCK = 32;
  localparam int SAMPLE_PERIOD_US  = 4;
  localparam int BLOCK_US          = SAMPLES_PER_BLOCK * SAMPLE_PERIOD_US;
  localparam int NEAR_LIMIT_US     = 1000;
  localparam int NEAR_BLOCKS       = NEAR_LIMIT_US / BLOCK_US;

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 16;
  localparam int DIST_W   = 14;
  localparam int SEC_W    = 2;
  localparam int HITS_W   = 3;
  localparam int BC_W     = 16;
  localparam int IDX_W    = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
  localparam int CFG_IDX_W = 1;

  // Unsaturated sample time needs room for block_count * BLOCK_US plus the offset.
  localparam int TFULL_W  = BC_W + $clog2(BLOCK_US) + 1;

  localparam logic [HITS_W-1:0]   HIT_MAX    = '1;
  localparam logic [HITS_W-1:0]   HIT_LATCH  = HITS_W'(3);
  localparam logic [BC_W-1:0]     BC_MAX     = '1;
  localparam logic [TIME_W-1:0]   TIME_MAX   = '1;

  // Distance = (t - 200) * 34 / 200, done as a reciprocal multiply.
  localparam int TIME_OFFSET_US  = 200;
  localparam int MIN_DISTANCE_MM = 29;
  localparam int DIST_SHIFT      = 24;
  localparam int DIST_MUL_W      = 22;
  localparam int DIST_MUL        = (34 * (2 ** DIST_SHIFT) + 199) / 200;
  localparam int PROD_W          = TIME_W + DIST_MUL_W;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_W-1:0] NEAR_THR_RST = SAMPLE_W'(2000);
  localparam logic [SAMPLE_W-1:0] FAR_THR_RST  = SAMPLE_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_THR = 1'b0,
    CFG_FAR_THR  = 1'b1
  } cfg_reg_e;

  typedef enum logic [SEC_W-1:0] {
    SEC_NONE = 2'd0,
    SEC_NEAR = 2'd1,
    SEC_FAR  = 2'd2
  } section_e;

  // Capture state snapshot handed to the distance stage on a last sample.
  typedef struct packed {
    logic [TIME_W-1:0]   peak_time;
    section_e            section;
    logic [SAMPLE_W-1:0] peak_value;
  } snap_t;

endpackage

[src/uepr_if.sv]
interface uepr_in_if;
  logic                            valid;
  logic                            ready;
  logic [uepr_pkg::SAMPLE_W-1:0]   sample;
  logic                            first;
  logic                            last;

  modport source (output valid, sample, first, last, input ready);
  modport sink   (input valid, sample, first, last, output ready);
endinterface

interface uepr_out_if;
  logic                            valid;
  logic                            ready;
  logic [uepr_pkg::DIST_W-1:0]     distance_mm;
  logic [uepr_pkg::SEC_W-1:0]      section;
  logic [uepr_pkg::SAMPLE_W-1:0]   peak_value;
  logic [uepr_pkg::TIME_W-1:0]     peak_time_us;

  modport source (output valid, distance_mm, section, peak_value, peak_time_us, input ready);
  modport sink   (input valid, distance_mm, section, peak_value, peak_time_us, output ready);
endinterface

interface uepr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [uepr_pkg::CFG_IDX_W-1:0]  index;
  logic [uepr_pkg::SAMPLE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/ultrasonic_echo_peak_ranger.sv]
// Output: a last sample's result is registered in the snapshot register, then with its distance in the output register.
// Throughput: one sample per cycle while in_i.ready is high; the capture state updates in the accept cycle and
// a two-register output pipeline (snapshot, then the distance multiply) decouples stalls.
// Reset: rst_ni is asynchronous and active low; it clears the capture state and the pipeline valid flags
// and sets the thresholds to 2000 (near) and 1000 (far). Config writes are always accepted and are registered.
module ultrasonic_echo_peak_ranger (
  input  logic        clk_i,
  input  logic        rst_ni,
  uepr_in_if.sink     in_i,
  uepr_cfg_if.sink    cfg_i,
  uepr_out_if.source  out_o
);

  logic [uepr_pkg::SAMPLE_W-1:0] near_thr_q, far_thr_q;

  logic [uepr_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [uepr_pkg::BC_W-1:0]     bc_q, bc_d;
  logic [uepr_pkg::HITS_W-1:0]   near_hits_q, near_hits_d;
  logic [uepr_pkg::HITS_W-1:0]   far_hits_q, far_hits_d;
  logic [uepr_pkg::SAMPLE_W-1:0] best_value_q, best_value_d;
  logic [uepr_pkg::TIME_W-1:0]   best_time_q, best_time_d;
  uepr_pkg::section_e            section_q, section_d;

  logic [uepr_pkg::IDX_W-1:0]    b_idx;
  logic [uepr_pkg::BC_W-1:0]     b_bc;
  logic [uepr_pkg::HITS_W-1:0]   b_near_hits, b_far_hits;
  logic [uepr_pkg::SAMPLE_W-1:0] b_best_value;
  logic [uepr_pkg::TIME_W-1:0]   b_best_time;
  uepr_pkg::section_e            b_section;

  logic                          in_acc;
  logic                          is_near;
  logic                          hit;
  logic                          block_end;
  logic [uepr_pkg::SAMPLE_W-1:0] thr;
  logic [uepr_pkg::TFULL_W-1:0]  t_full;
  logic [uepr_pkg::TIME_W-1:0]   t_sat;

  logic            push_ready;
  uepr_pkg::snap_t push_data;

  assign in_acc    = in_i.valid && push_ready;
  assign in_i.ready = push_ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_thr_q <= uepr_pkg::NEAR_THR_RST;
      far_thr_q  <= uepr_pkg::FAR_THR_RST;
    end else if (cfg_i.valid) begin
      unique case (uepr_pkg::cfg_reg_e'(cfg_i.index))
        uepr_pkg::CFG_NEAR_THR: near_thr_q <= cfg_i.data;
        uepr_pkg::CFG_FAR_THR:  far_thr_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A first sample starts from a cleared capture before it is evaluated.
  always_comb begin
    if (in_i.first) begin
      b_idx        = '0;
      b_bc         = '0;
      b_near_hits  = '0;
      b_far_hits   = '0;
      b_best_value = '0;
      b_best_time  = '0;
      b_section    = uepr_pkg::SEC_NONE;
    end else begin
      b_idx        = idx_q;
      b_bc         = bc_q;
      b_near_hits  = near_hits_q;
      b_far_hits   = far_hits_q;
      b_best_value = best_value_q;
      b_best_time  = best_time_q;
      b_section    = section_q;
    end
  end

  always_comb begin
    is_near   = b_bc < uepr_pkg::BC_W'(uepr_pkg::NEAR_BLOCKS);
    thr       = is_near ? near_thr_q : far_thr_q;
    hit       = in_i.sample > thr;
    block_end = b_idx == uepr_pkg::IDX_W'(uepr_pkg::SAMPLES_PER_BLOCK - 1);
    t_full    = uepr_pkg::TFULL_W'(b_bc) * uepr_pkg::TFULL_W'(uepr_pkg::BLOCK_US)
              + uepr_pkg::TFULL_W'(b_idx) * uepr_pkg::TFULL_W'(uepr_pkg::SAMPLE_PERIOD_US);
    t_sat     = (t_full > uepr_pkg::TFULL_W'(uepr_pkg::TIME_MAX)) ? uepr_pkg::TIME_MAX
                                                                  : t_full[uepr_pkg::TIME_W-1:0];

    idx_d        = b_idx;
    bc_d         = b_bc;
    near_hits_d  = b_near_hits;
    far_hits_d   = b_far_hits;
    best_value_d = b_best_value;
    best_time_d  = b_best_time;
    section_d    = b_section;

    // Once the near section has latched, samples leave the capture untouched.
    if (b_section != uepr_pkg::SEC_NEAR) begin
      if (hit) begin
        if (is_near) begin
          if (b_near_hits != uepr_pkg::HIT_MAX) near_hits_d = b_near_hits + 1'b1;
        end else begin
          if (b_far_hits != uepr_pkg::HIT_MAX) far_hits_d = b_far_hits + 1'b1;
        end
        if (in_i.sample > b_best_value) begin
          best_value_d = in_i.sample;
          best_time_d  = t_sat;
        end
      end
      if (block_end) begin
        idx_d = '0;
        if (near_hits_d > uepr_pkg::HIT_LATCH) begin
          section_d = uepr_pkg::SEC_NEAR;
        end else if (far_hits_d > uepr_pkg::HIT_LATCH) begin
          section_d = uepr_pkg::SEC_FAR;
        end
        if (b_bc != uepr_pkg::BC_MAX) bc_d = b_bc + 1'b1;
      end else begin
        idx_d = b_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      bc_q         <= '0;
      near_hits_q  <= '0;
      far_hits_q   <= '0;
      best_value_q <= '0;
      best_time_q  <= '0;
      section_q    <= uepr_pkg::SEC_NONE;
    end else if (in_acc) begin
      idx_q        <= idx_d;
      bc_q         <= bc_d;
      near_hits_q  <= near_hits_d;
      far_hits_q   <= far_hits_d;
      best_value_q <= best_value_d;
      best_time_q  <= best_time_d;
      section_q    <= section_d;
    end
  end

  assign push_data.peak_time  = best_time_d;
  assign push_data.section    = section_d;
  assign push_data.peak_value = best_value_d;

  uepr_dist u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid && in_i.last),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .out_o        (out_o)
  );

  // A nonzero distance is only reported with a latched section.
  a_dist_needs_section: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.distance_mm != '0)) |-> (out_o.section != uepr_pkg::SEC_NONE))
    else $error("distance reported without a latched section");

  // With the near section latched, only a first sample may change the peak.
  a_near_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((section_q == uepr_pkg::SEC_NEAR) && !(in_acc && in_i.first))
      |=> ($stable(best_value_q) && $stable(best_time_q) && $stable(bc_q)))
    else $error("capture state changed after near latch");

  // The latched section only changes at a block end or on a first sample.
  a_section_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.first && !block_end) |=> $stable(section_q))
    else $error("section changed in mid-block");

endmodule

[src/uepr_dist.sv]
module uepr_dist (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  uepr_pkg::snap_t push_data_i,
  output logic            push_ready_o,
  uepr_out_if.source      out_o
);

  logic            s1_valid_q, s1_valid_d;
  uepr_pkg::snap_t s1_q;
  logic            s2_valid_q, s2_valid_d;
  uepr_pkg::snap_t s2_q;
  logic [uepr_pkg::DIST_W-1:0] dist_q, dist_d;

  logic s2_ready;
  logic s1_move;
  logic push_acc;

  logic                          short_time;
  logic [uepr_pkg::TIME_W-1:0]   offs_time;
  logic [uepr_pkg::PROD_W-1:0]   prod;
  logic [uepr_pkg::DIST_W-1:0]   dist_raw;

  assign s2_ready     = !s2_valid_q || out_o.ready;
  assign s1_move      = s1_valid_q && s2_ready;
  assign push_ready_o = !s1_valid_q || s2_ready;
  assign push_acc     = push_valid_i && push_ready_o;

  assign s1_valid_d = push_acc || (s1_valid_q && !s2_ready);
  assign s2_valid_d = s1_move || (s2_valid_q && !out_o.ready);

  // The constant reciprocal is exact for every 16-bit time offset.
  always_comb begin
    short_time = s1_q.peak_time < uepr_pkg::TIME_W'(uepr_pkg::TIME_OFFSET_US);
    offs_time  = s1_q.peak_time - uepr_pkg::TIME_W'(uepr_pkg::TIME_OFFSET_US);
    prod       = uepr_pkg::PROD_W'(offs_time) * uepr_pkg::PROD_W'(uepr_pkg::DIST_MUL);
    dist_raw   = prod[uepr_pkg::DIST_SHIFT +: uepr_pkg::DIST_W];
    if (short_time || (s1_q.section == uepr_pkg::SEC_NONE) ||
        (dist_raw < uepr_pkg::DIST_W'(uepr_pkg::MIN_DISTANCE_MM))) begin
      dist_d = '0;
    end else begin
      dist_d = dist_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      s1_q <= push_data_i;
    end
    if (s1_move) begin
      s2_q   <= s1_q;
      dist_q <= dist_d;
    end
  end

  assign out_o.valid        = s2_valid_q;
  assign out_o.distance_mm  = dist_q;
  assign out_o.section      = s2_q.section;
  assign out_o.peak_value   = s2_q.peak_value;
  assign out_o.peak_time_us = s2_q.peak_time;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import uepr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS = 100;
  localparam int RANDOM_ITEMS = 100;
  localparam int PHASE_ITEMS = 20;
  localparam int MIN_RANDOM_RANGES = 6;
  localparam int MM_NUM = 34;
  localparam int MM_DEN = 200;

  typedef struct {
    logic [DIST_W-1:0]   distance_mm;
    section_e            section;
    logic [SAMPLE_W-1:0] peak_value;
    logic [TIME_W-1:0]   peak_time_us;
  } range_result_t;

  logic clk_i;
  logic rst_ni;

  uepr_in_if  echo_in ();
  uepr_cfg_if cfg_wr ();
  uepr_out_if range_out ();

  ultrasonic_echo_peak_ranger i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (echo_in),
    .cfg_i  (cfg_wr),
    .out_o  (range_out)
  );

  // Expected ranging results, oldest first.
  range_result_t echo_ranges_q[$];

  // Predictor copy of the thresholds and the capture state.
  logic [SAMPLE_W-1:0] thr_near;
  logic [SAMPLE_W-1:0] thr_far;
  logic [IDX_W-1:0]    cap_idx;
  logic [BC_W-1:0]     cap_blocks;
  logic [HITS_W-1:0]   cap_near_hits;
  logic [HITS_W-1:0]   cap_far_hits;
  logic [SAMPLE_W-1:0] cap_peak_val;
  logic [TIME_W-1:0]   cap_peak_time;
  section_e            cap_section;

  int  n_errors;
  int  n_live_items;
  int  n_ranges_due;
  int  quiet_cycles;
  bit  src_idle_en;
  bit  sink_idle_en;
  bit  hold_off_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_capture();
    cap_idx       = '0;
    cap_blocks    = '0;
    cap_near_hits = '0;
    cap_far_hits  = '0;
    cap_peak_val  = '0;
    cap_peak_time = '0;
    cap_section   = SEC_NONE;
  endtask

  // Applies one accepted sample to the predicted capture state and queues
  // the ranging result when the sample closes the capture.
  task automatic predict_echo(input logic [SAMPLE_W-1:0] s, input logic f, input logic l);
    int unsigned         t_raw;
    int unsigned         dist_mm;
    logic                near_win;
    logic [SAMPLE_W-1:0] thr;
    range_result_t       r;
    if (f) clear_capture();
    // Once the near section is latched the capture is frozen.
    if (cap_section != SEC_NEAR) begin
      n_live_items++;
      near_win = cap_blocks < NEAR_BLOCKS;
      thr = near_win ? thr_near : thr_far;
      if (s > thr) begin
        if (near_win) begin
          if (cap_near_hits != HIT_MAX) cap_near_hits = cap_near_hits + 1'b1;
        end else begin
          if (cap_far_hits != HIT_MAX) cap_far_hits = cap_far_hits + 1'b1;
        end
        if (s > cap_peak_val) begin
          t_raw = BLOCK_US * int'(cap_blocks) + SAMPLE_PERIOD_US * int'(cap_idx);
          cap_peak_val = s;
          cap_peak_time = (t_raw > TIME_MAX) ? TIME_MAX : t_raw[TIME_W-1:0];
        end
      end
      if (int'(cap_idx) + 1 >= SAMPLES_PER_BLOCK) begin
        cap_idx = '0;
        if (cap_near_hits > HIT_LATCH) cap_section = SEC_NEAR;
        else if (cap_far_hits > HIT_LATCH) cap_section = SEC_FAR;
        if (cap_blocks != BC_MAX) cap_blocks = cap_blocks + 1'b1;
      end else begin
        cap_idx = cap_idx + 1'b1;
      end
    end
    if (l) begin
      dist_mm = 0;
      if (cap_peak_time >= TIME_OFFSET_US && cap_section != SEC_NONE) begin
        dist_mm = (int'(cap_peak_time) - TIME_OFFSET_US) * MM_NUM / MM_DEN;
        if (dist_mm < MIN_DISTANCE_MM) dist_mm = 0;
      end
      r.distance_mm  = dist_mm[DIST_W-1:0];
      r.section      = cap_section;
      r.peak_value   = cap_peak_val;
      r.peak_time_us = cap_peak_time;
      echo_ranges_q.push_back(r);
      n_ranges_due++;
    end
  endtask

  // Offers one sample and returns at the edge of its transfer. Valid is left
  // high so that a following sample can go out back to back.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic f, input logic l);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      echo_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    echo_in.valid  <= 1'b1;
    echo_in.sample <= s;
    echo_in.first  <= f;
    echo_in.last   <= l;
    do @(posedge clk_i); while (!echo_in.ready);
    predict_echo(s, f, l);
  endtask

  // Waits until every expected range has come out and the pipeline has settled.
  task automatic wait_quiet();
    echo_in.valid <= 1'b0;
    while (echo_ranges_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e r, input logic [SAMPLE_W-1:0] v);
    wait_quiet();
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= r;
    cfg_wr.data  <= v;
    do @(posedge clk_i); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    if (r == CFG_NEAR_THR) thr_near = v;
    else thr_far = v;
  endtask

  // A run of identical samples with an optional stretch of hit values inside.
  task automatic send_train(input int len, input logic [SAMPLE_W-1:0] base,
                            input logic [SAMPLE_W-1:0] hit_val, input int hit_from,
                            input int hit_cnt, input logic with_first, input logic with_last);
    logic [SAMPLE_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      s = (i >= hit_from && i < hit_from + hit_cnt) ? hit_val : base;
      send_sample(s, with_first && i == 0, with_last && i == len - 1);
    end
  endtask

  // One capture of noise with a single echo burst at a random place.
  task automatic send_capture(input int len, input logic with_first);
    int echo_at;
    int echo_len;
    int echo_lo;
    int noise_max;
    logic [SAMPLE_W-1:0] s;
    echo_at  = $urandom_range(0, len - 1);
    echo_len = $urandom_range(1, 12);
    echo_lo  = $urandom_range(1000, 4000);
    case ($urandom_range(0, 3))
      0: noise_max = 200;
      1: noise_max = 900;
      2: noise_max = 2100;
      default: noise_max = 4095;
    endcase
    for (int i = 0; i < len; i++) begin
      if (i >= echo_at && i < echo_at + echo_len) s = $urandom_range(echo_lo, 4095);
      else s = $urandom_range(0, noise_max);
      send_sample(s, with_first && i == 0, i == len - 1);
    end
  endtask

  task automatic test_directed();
    send_sample(12'd4095, 1'b1, 1'b1);
    send_sample(12'd0, 1'b1, 1'b1);
    send_sample(12'd0, 1'b1, 1'b0);
    // A sample equal to the threshold is not a hit.
    send_sample(12'd2001, 1'b0, 1'b0);
    send_sample(12'd2000, 1'b0, 1'b1);
    // A last sample without a new first keeps building on the same capture.
    send_sample(12'd3000, 1'b0, 1'b1);
    send_sample(12'd4095, 1'b0, 1'b0);
    send_sample(12'd1, 1'b0, 1'b1);
    send_sample(12'd1234, 1'b1, 1'b1);
    send_sample(12'd2730, 1'b1, 1'b0);
    send_sample(12'd1365, 1'b0, 1'b1);
    wait_quiet();
  endtask

  task automatic test_section_latch();
    // Four near hits latch the near section; later samples are ignored.
    send_train(32, 12'd2000, 12'd3000, 10, 4, 1'b1, 1'b0);
    send_train(6, 12'd4095, 12'd0, 0, 0, 1'b0, 1'b1);
    // Three hits are not enough to latch.
    send_train(33, 12'd1999, 12'd2500, 20, 3, 1'b1, 1'b1);
    // Quiet near window, then four far hits in the first far block.
    send_train(NEAR_BLOCKS * SAMPLES_PER_BLOCK, 12'd0, 12'd0, 0, 0, 1'b1, 1'b0);
    send_train(32, 12'd1000, 12'd1500, 5, 4, 1'b0, 1'b0);
    send_train(10, 12'd0, 12'd0, 0, 0, 1'b0, 1'b1);
    wait_quiet();
  endtask

  // Peak times around the 200 us offset and around the 29 mm floor.
  task automatic test_distance_edges();
    int peak_slots[5] = '{49, 50, 92, 93, 94};
    foreach (peak_slots[k]) begin
      send_train(peak_slots[k] + 1, 12'd0, 12'd4095, peak_slots[k], 1, 1'b1, 1'b0);
      send_train(3, 12'd2500, 12'd0, 0, 0, 1'b0, 1'b0);
      send_train(4 * SAMPLES_PER_BLOCK - peak_slots[k] - 4, 12'd0, 12'd0, 0, 0, 1'b0, 1'b1);
    end
    wait_quiet();
  endtask

  // The receiver stops for a long stretch while one-sample captures keep coming,
  // so the output pipeline fills and the input has to stall.
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(12'($urandom_range(0, 4095)), 1'b1, 1'b1);
    wait_quiet();
  endtask

  task automatic test_random();
    int kind;
    int start_items;
    int start_ranges;
    int n;
    start_ranges = n_ranges_due;
    for (int p = 0; p < 40; p++) begin
      if (p >= RANDOM_ITEMS / PHASE_ITEMS && n_ranges_due - start_ranges >= MIN_RANDOM_RANGES)
        break;
      case (p)
        0: begin
          write_reg(CFG_NEAR_THR, NEAR_THR_RST);
          write_reg(CFG_FAR_THR, FAR_THR_RST);
        end
        1: begin
          write_reg(CFG_NEAR_THR, 12'd0);
          write_reg(CFG_FAR_THR, 12'd0);
        end
        2: begin
          write_reg(CFG_NEAR_THR, 12'd4095);
          write_reg(CFG_FAR_THR, 12'd4095);
        end
        3: begin
          write_reg(CFG_NEAR_THR, 12'd0);
          write_reg(CFG_FAR_THR, 12'd4095);
        end
        default: begin
          write_reg(CFG_NEAR_THR, 12'($urandom_range(0, 4095)));
          write_reg(CFG_FAR_THR, 12'($urandom_range(0, 4095)));
        end
      endcase
      src_idle_en = (p % 3 != 2);
      sink_idle_en = (p % 4 != 3);
      start_items = n_live_items;
      while (n_live_items - start_items < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          send_capture($urandom_range(1, 40), 1'b1);
        end else if (kind < 70) begin
          send_capture($urandom_range(200, 300), 1'b1);
        end else if (kind < 80) begin
          send_capture($urandom_range(1, 60), 1'b0);
        end else if (kind < 90) begin
          send_capture($urandom_range(33, 150), 1'b1);
        end else begin
          // Loose samples with first and last set at random.
          n = $urandom_range(1, 16);
          for (int i = 0; i < n; i++)
            send_sample(12'($urandom_range(0, 4095)), $urandom_range(0, 3) == 0,
                        $urandom_range(0, 3) == 0);
        end
      end
    end
    wait_quiet();
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_ranges
    range_result_t want;
    if (rst_ni && range_out.valid && range_out.ready) begin
      if (echo_ranges_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected range transfer, expected none, got distance %0d",
                   $time, range_out.distance_mm);
      end else begin
        want = echo_ranges_q.pop_front();
        check_field("distance_mm", 16'(want.distance_mm), 16'(range_out.distance_mm));
        check_field("section", 16'(want.section), 16'(range_out.section));
        check_field("peak_value", 16'(want.peak_value), 16'(range_out.peak_value));
        check_field("peak_time_us", want.peak_time_us, range_out.peak_time_us);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    range_out.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        range_out.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        range_out.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      range_out.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (echo_in.valid && echo_in.ready) || (range_out.valid && range_out.ready) ||
        (cfg_wr.valid && cfg_wr.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d ranges still pending", $time,
               echo_ranges_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    echo_in.valid  <= 1'b0;
    echo_in.sample <= '0;
    echo_in.first  <= 1'b0;
    echo_in.last   <= 1'b0;
    cfg_wr.valid   <= 1'b0;
    cfg_wr.index   <= CFG_NEAR_THR;
    cfg_wr.data    <= '0;
    n_errors = 0;
    n_live_items = 0;
    n_ranges_due = 0;
    quiet_cycles = 0;
    hold_off_req = 1'b0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    thr_near = NEAR_THR_RST;
    thr_far = FAR_THR_RST;
    clear_capture();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_section_latch();
    test_distance_edges();
    test_random();
    test_backpressure();

    wait_quiet();
    if (n_errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
